// File: design/xmodem_crc_packet_framer_assert.svh
// Assertion macros, compiled out for synthesis
`ifndef XMODEM_CRC_PACKET_FRAMER_ASSERT_SVH
`define XMODEM_CRC_PACKET_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define XCPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("xcpf: same-cycle check failed");
`define XCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("xcpf: next-cycle check failed");
`else
`define XCPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define XCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/xcpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcpf_pkg;

    localparam int PACKET_BYTES = 128;
    localparam int PLEN = (PACKET_BYTES < 2) ? 2 : ((PACKET_BYTES > 128) ? 128 : PACKET_BYTES);

    localparam logic [7:0]  BYTE_SOH    = 8'h01;
    localparam logic [7:0]  BYTE_EOT    = 8'h04;
    localparam logic [7:0]  BYTE_ETB    = 8'h17;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  PAD_RESET   = 8'hFF;
    localparam logic [7:0]  START_RESET = 8'h01;

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_END   = 1'b1;
    localparam logic CFG_PAD   = 1'b0;
    localparam logic CFG_START = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } t_crc_ctl;

endpackage

`default_nettype wire

// File: design/xcpf_crc.sv
`timescale 1ns / 1ps
`default_nettype none

module xcpf_crc (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire xcpf_pkg::t_crc_ctl i_ctl,
    input  wire  [7:0]          i_byte,
    output logic [15:0]         o_crc
);
    import xcpf_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_sr;
    logic [7:0]  n_sr;
    logic        w_fb;

    assign w_fb = r_crc[15] ^ r_sr[7];

    always_comb begin
        n_crc = r_crc;
        n_sr  = r_sr;
        if (i_ctl.shift) begin
            n_crc = {r_crc[14:0], 1'b0} ^ (w_fb ? CRC_POLY : 16'h0000);
            n_sr  = {r_sr[6:0], 1'b0};
        end
        if (i_ctl.load) begin
            n_sr = i_byte;
        end
        if (i_ctl.clear) begin
            n_crc = 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else begin
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr <= n_sr;
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

// File: design/xmodem_crc_packet_framer.sv
// After a request is accepted, the sequencer moves to its first output state, header or not, and
// registers the first result there once the output is free. Each payload byte is emitted, then
// shifted bit-serially through the CRC before the next request; an end request also shifts each pad byte.
// A stalled output holds the sequencer; one request is in flight at a time.
// Reset: synchronous, active low; pad byte 0xFF, start sequence 1, CRC and count cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "xmodem_crc_packet_framer_assert.svh"

module xmodem_crc_packet_framer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] copies
    output logic        m_axis_tlast
);
    import xcpf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HDR0  = 4'd1;
    localparam logic [3:0] S_HDR1  = 4'd2;
    localparam logic [3:0] S_HDR2  = 4'd3;
    localparam logic [3:0] S_DATA  = 4'd4;
    localparam logic [3:0] S_PAD   = 4'd5;
    localparam logic [3:0] S_CRC   = 4'd6;
    localparam logic [3:0] S_CRCHI = 4'd7;
    localparam logic [3:0] S_CRCLO = 4'd8;
    localparam logic [3:0] S_EOT   = 4'd9;
    localparam logic [3:0] S_ETB   = 4'd10;

    logic [3:0]  r_state, n_state;
    logic        r_req, n_req;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_pad, n_pad;
    logic [7:0]  r_start, n_start;
    logic [7:0]  r_seq, n_seq;
    logic [6:0]  r_bytes, n_bytes;
    logic        r_in_transfer, n_in_transfer;
    logic [7:0]  r_left, n_left;
    logic [2:0]  r_bit, n_bit;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [7:0]  r_out_copies, n_out_copies;
    logic        r_out_last, n_out_last;

    logic        w_out_free;
    logic        w_full;
    logic [7:0]  w_pad_copies;
    logic [15:0] w_crc;
    logic [7:0]  w_crc_byte;
    t_crc_ctl    w_ctl;

    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_full       = ({1'b0, r_bytes} == 8'(PLEN - 1));
    assign w_pad_copies = 8'(PLEN) - {1'b0, r_bytes};
    assign w_crc_byte   = (r_req == REQ_END) ? r_pad : r_data;

    xcpf_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (w_crc_byte),
        .o_crc   (w_crc)
    );

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_data        = r_data;
        n_pad         = r_pad;
        n_start       = r_start;
        n_seq         = r_seq;
        n_bytes       = r_bytes;
        n_in_transfer = r_in_transfer;
        n_left        = r_left;
        n_bit         = r_bit;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_byte    = r_out_byte;
        n_out_copies  = r_out_copies;
        n_out_last    = r_out_last;
        w_ctl         = '0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req  = s_axis_tuser;
                    n_data = s_axis_tdata;
                    if (s_axis_tuser == REQ_DATA) begin
                        n_in_transfer = 1'b1;
                        n_state = (r_bytes == 7'd0) ? S_HDR0 : S_DATA;
                    end else begin
                        n_state = (r_bytes != 7'd0) ? S_PAD : S_EOT;
                    end
                end
            end
            S_HDR0: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = BYTE_SOH;
                    n_out_copies = 8'd1;
                    n_out_last   = 1'b0;
                    n_state      = S_HDR1;
                end
            end
            S_HDR1: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_seq;
                    n_out_copies = 8'd1;
                    n_out_last   = 1'b0;
                    n_state      = S_HDR2;
                end
            end
            S_HDR2: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = ~r_seq;
                    n_out_copies = 8'd1;
                    n_out_last   = 1'b0;
                    n_state      = S_DATA;
                end
            end
            S_DATA: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_data;
                    n_out_copies = 8'd1;
                    n_out_last   = !w_full;
                    w_ctl.load   = 1'b1;
                    n_left       = 8'd1;
                    n_bit        = 3'd0;
                    n_state      = S_CRC;
                end
            end
            S_PAD: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_pad;
                    n_out_copies = w_pad_copies;
                    n_out_last   = 1'b0;
                    w_ctl.load   = 1'b1;
                    n_left       = w_pad_copies;
                    n_bit        = 3'd0;
                    n_state      = S_CRC;
                end
            end
            S_CRC: begin
                w_ctl.shift = 1'b1;
                n_bit       = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        if (r_req == REQ_END) begin
                            n_state = S_CRCHI;
                        end else begin
                            n_bytes = r_bytes + 7'd1;
                            n_state = w_full ? S_CRCHI : S_IDLE;
                        end
                    end else begin
                        w_ctl.load = 1'b1;
                    end
                end
            end
            S_CRCHI: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = w_crc[15:8];
                    n_out_copies = 8'd1;
                    n_out_last   = 1'b0;
                    n_state      = S_CRCLO;
                end
            end
            S_CRCLO: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = w_crc[7:0];
                    n_out_copies = 8'd1;
                    n_out_last   = (r_req == REQ_DATA);
                    w_ctl.clear  = 1'b1;
                    n_bytes      = 7'd0;
                    n_seq        = r_seq + 8'd1;
                    n_state      = (r_req == REQ_END) ? S_EOT : S_IDLE;
                end
            end
            S_EOT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = BYTE_EOT;
                    n_out_copies = 8'd1;
                    n_out_last   = 1'b0;
                    n_state      = S_ETB;
                end
            end
            S_ETB: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_byte    = BYTE_ETB;
                    n_out_copies  = 8'd1;
                    n_out_last    = 1'b1;
                    w_ctl.clear   = 1'b1;
                    n_bytes       = 7'd0;
                    n_seq         = r_start;
                    n_in_transfer = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAD: begin
                    n_pad = i_cfg_data;
                end
                CFG_START: begin
                    n_start = i_cfg_data;
                    if (!r_in_transfer) begin
                        n_seq = i_cfg_data;
                    end
                end
                default: begin
                    n_pad = r_pad;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pad         <= PAD_RESET;
            r_start       <= START_RESET;
            r_seq         <= START_RESET;
            r_bytes       <= 7'd0;
            r_in_transfer <= 1'b0;
            r_left        <= 8'd0;
            r_bit         <= 3'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pad         <= n_pad;
            r_start       <= n_start;
            r_seq         <= n_seq;
            r_bytes       <= n_bytes;
            r_in_transfer <= n_in_transfer;
            r_left        <= n_left;
            r_bit         <= n_bit;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_data       <= n_data;
        r_out_byte   <= n_out_byte;
        r_out_copies <= n_out_copies;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_copies, r_out_byte};
    assign m_axis_tlast  = r_out_last;

    `XCPF_ASSERT_SAME(a_empty_packet_crc_zero, i_clk, i_rst_n,
        (r_state == S_IDLE) && (r_bytes == 7'd0), w_crc == 16'h0000)
    `XCPF_ASSERT_SAME(a_crc_has_work, i_clk, i_rst_n,
        r_state == S_CRC, r_left != 8'd0)
    `XCPF_ASSERT_NEXT(a_header_first, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_DATA) && (r_bytes == 7'd0),
        r_state == S_HDR0)
    `XCPF_ASSERT_NEXT(a_end_restores_seq, i_clk, i_rst_n,
        (r_state == S_ETB) && w_out_free && !i_cfg_we,
        (r_seq == r_start) && !r_in_transfer)

endmodule

`default_nettype wire
